### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define RVLP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rvlp assertion failed");

// Clocked assertion that is also checked during and right after reset.
`define RVLP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rvlp assertion failed");

`endif

### hdl/rvlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_pkg
// Types and constants of the raw video line packetizer.
// ----------------------------------------------------------------------------
package rvlp_pkg;

   // configuration register widths
   localparam int FW_W       = 15;
   localparam int FH_W       = 16;
   localparam int BPP_W      = 7;
   localparam int MP_W       = 14;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;

   // state widths
   localparam int LINE_W     = 15;
   localparam int LBYTES_W   = 18;
   localparam int CHUNK_W    = 14;
   localparam int SEQ_W      = 16;
   localparam int PROD_W     = FW_W + BPP_W;

   // pixel offset divider: (line_offset * 8) / bpp, low 15 quotient bits kept
   localparam int DIVD_W     = LBYTES_W + 3;
   localparam int QUOT_W     = 15;
   localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

   // output byte index within one request's results
   localparam int IDX_W      = 5;
   localparam logic [IDX_W-1:0] IDX_FIRST   = 5'd0;
   localparam logic [IDX_W-1:0] IDX_ZERO_LO = 5'd0;
   localparam logic [IDX_W-1:0] IDX_ZERO_HI = 5'd11;
   localparam logic [IDX_W-1:0] IDX_SEQ_HI  = 5'd12;
   localparam logic [IDX_W-1:0] IDX_SEQ_LO  = 5'd13;
   localparam logic [IDX_W-1:0] IDX_LEN_HI  = 5'd14;
   localparam logic [IDX_W-1:0] IDX_LEN_LO  = 5'd15;
   localparam logic [IDX_W-1:0] IDX_LINE_HI = 5'd16;
   localparam logic [IDX_W-1:0] IDX_LINE_LO = 5'd17;
   localparam logic [IDX_W-1:0] IDX_OFFS_HI = 5'd18;
   localparam logic [IDX_W-1:0] IDX_OFFS_LO = 5'd19;
   localparam logic [IDX_W-1:0] IDX_DATA    = 5'd20;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BPP_W-1:0] BPP_MAX    = 7'd64;
   localparam logic [FH_W-1:0]  HEIGHT_MAX = 16'h8000;
   localparam logic [MP_W-1:0]  RTP_FIXED  = 14'd8;

   localparam logic [FW_W-1:0]  RST_WIDTH  = 15'd1920;
   localparam logic [FH_W-1:0]  RST_HEIGHT = 16'd1080;
   localparam logic [BPP_W-1:0] RST_BPP    = 7'd24;
   localparam logic [MP_W-1:0]  RST_MAXPL  = 14'd1440;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_BITS_PER_PIXEL = 2'd2,
      CSR_MAX_PAYLOAD    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              wr;
      logic [FW_W-1:0]   width;
      logic [FH_W-1:0]   height;
      logic [BPP_W-1:0]  bpp;
      logic [MP_W-1:0]   max_payload;
   } cfg_type;

   // one request as classified by the front end
   typedef struct packed {
      logic               hdr;
      logic [7:0]         data;
      logic [SEQ_W-1:0]   seq;
      logic [CHUNK_W-1:0] chunk;
      logic [LINE_W-1:0]  line;
      logic [15:0]        offs;
      logic               pkt_end;
      logic               frame_end;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [BPP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

### hdl/rvlp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_div
// Restoring divider, one quotient bit per cycle, for the pixel offset.
// ----------------------------------------------------------------------------
module rvlp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rvlp_pkg::div_req_type req,
   output rvlp_pkg::div_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rvlp_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [rvlp_pkg::DIVD_W-1:0]     dvd_ff, dvd_in;
   logic [rvlp_pkg::BPP_W-1:0]      dsr_ff, dsr_in;
   logic [rvlp_pkg::BPP_W-1:0]      rem_ff, rem_in;
   logic [rvlp_pkg::QUOT_W-1:0]     quo_ff, quo_in;
   logic [rvlp_pkg::BPP_W:0]        trial;
   logic [rvlp_pkg::BPP_W:0]        diff;
   logic                            ge;

   assign trial = {rem_ff, dvd_ff[rvlp_pkg::DIVD_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = rvlp_pkg::DIV_CNT_W'(rvlp_pkg::DIVD_W);
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[rvlp_pkg::BPP_W-1:0] : trial[rvlp_pkg::BPP_W-1:0];
         quo_in  = {quo_ff[rvlp_pkg::QUOT_W-2:0], ge};
         dvd_in  = {dvd_ff[rvlp_pkg::DIVD_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == rvlp_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

### hdl/rvlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_front
// Accepts input bytes, tracks line/chunk position and classifies each
// request as data only or header plus data.
// ----------------------------------------------------------------------------
module rvlp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  rvlp_pkg::cfg_type     cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  q_room,
   output logic                  push_valid,
   output rvlp_pkg::entry_type   push_entry,
   output rvlp_pkg::div_req_type div_req,
   input  rvlp_pkg::div_rsp_type div_rsp
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_DIV  = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;

   // derived configuration
   logic [rvlp_pkg::BPP_W-1:0]    bpp_in, bpp_ff;
   logic [rvlp_pkg::FH_W-1:0]     height_in, height_ff;
   logic [rvlp_pkg::PROD_W-1:0]   prod;
   logic [rvlp_pkg::LBYTES_W-1:0] lbytes_in, lbytes_ff;
   logic [rvlp_pkg::MP_W-1:0]     room_in, room_ff;
   logic                          bad_in, bad_ff;
   logic                          hold_ff;

   // position state
   logic [rvlp_pkg::LINE_W-1:0]   line_ff, line_in;
   logic [rvlp_pkg::LBYTES_W-1:0] loff_ff, loff_in;
   logic [rvlp_pkg::CHUNK_W-1:0]  cleft_ff, cleft_in;
   logic [rvlp_pkg::SEQ_W-1:0]    seq_ff, seq_in;

   // packet start work
   logic [7:0]                    byte_ff, byte_in;
   logic [rvlp_pkg::CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic                          cont_ff, cont_in;
   logic [rvlp_pkg::LINE_W-1:0]   line_s;
   logic [rvlp_pkg::LBYTES_W-1:0] loff_s;
   logic [rvlp_pkg::LBYTES_W-1:0] remaining;
   logic                          gt_room;

   // position update for one data byte
   logic                          accept;
   logic [rvlp_pkg::CHUNK_W-1:0]  cl_src, cl_dec;
   logic [rvlp_pkg::LBYTES_W-1:0] lo_inc;
   logic [rvlp_pkg::FH_W-1:0]     line_inc;
   logic                          pend, lend, fend;

   assign bpp_in    = (cfg.bpp > rvlp_pkg::BPP_MAX) ? rvlp_pkg::BPP_MAX : cfg.bpp;
   assign height_in = (cfg.height > rvlp_pkg::HEIGHT_MAX) ? rvlp_pkg::HEIGHT_MAX : cfg.height;
   assign prod      = rvlp_pkg::PROD_W'(cfg.width) * rvlp_pkg::PROD_W'(bpp_in);
   assign lbytes_in = prod[rvlp_pkg::LBYTES_W+2:3];
   assign room_in   = cfg.max_payload - rvlp_pkg::RTP_FIXED;
   assign bad_in    = (cfg.max_payload <= rvlp_pkg::RTP_FIXED) || (lbytes_in == '0) ||
                      (height_in == '0);

   // derived values are registered; hold_ff keeps the request side off after a register write
   assign req_tready = (state_ff == ST_IDLE) && !hold_ff && q_room;
   assign accept     = req_tvalid && req_tready;

   // stale position restarts at a packet start
   assign line_s    = ({1'b0, line_ff} >= height_ff) ? '0 : line_ff;
   assign loff_s    = (loff_ff >= lbytes_ff) ? '0 : loff_ff;
   assign remaining = lbytes_ff - loff_s;
   assign gt_room   = remaining > rvlp_pkg::LBYTES_W'(room_ff);

   assign cl_src   = (state_ff == ST_DIV) ? chunk_ff : cleft_ff;
   assign cl_dec   = cl_src - 1'b1;
   assign lo_inc   = loff_ff + 1'b1;
   assign line_inc = {1'b0, line_ff} + 1'b1;
   assign pend     = cl_dec == '0;
   assign lend     = lo_inc >= lbytes_ff;
   assign fend     = pend && lend && (line_inc >= height_ff);

   assign push_valid = (accept && !bad_ff && (cleft_ff != '0)) ||
                       ((state_ff == ST_DIV) && div_rsp.done);

   always_comb begin
      push_entry.hdr       = state_ff == ST_DIV;
      push_entry.data      = (state_ff == ST_DIV) ? byte_ff : req_tdata;
      push_entry.seq       = seq_ff;
      push_entry.chunk     = chunk_ff;
      push_entry.line      = line_ff;
      push_entry.offs      = {cont_ff, div_rsp.quot};
      push_entry.pkt_end   = pend;
      push_entry.frame_end = fend;
   end

   assign div_req.start    = state_ff == ST_PREP;
   assign div_req.dividend = {loff_s, 3'b000};
   assign div_req.divisor  = bpp_ff;

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      loff_in  = loff_ff;
      cleft_in = cleft_ff;
      seq_in   = seq_ff;
      byte_in  = byte_ff;
      chunk_in = chunk_ff;
      cont_in  = cont_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !bad_ff && (cleft_ff == '0)) begin
               byte_in  = req_tdata;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            line_in  = line_s;
            loff_in  = loff_s;
            chunk_in = gt_room ? room_ff : remaining[rvlp_pkg::CHUNK_W-1:0];
            cont_in  = gt_room;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (push_valid) begin
         cleft_in = cl_dec;
         loff_in  = lo_inc;
         if (pend) begin
            seq_in = seq_ff + 1'b1;
            if (lend) begin
               loff_in = '0;
               if (fend) begin
                  line_in = '0;
                  seq_in  = '0;
               end else begin
                  line_in = line_inc[rvlp_pkg::LINE_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         line_ff  <= '0;
         loff_ff  <= '0;
         cleft_ff <= '0;
         seq_ff   <= '0;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
         loff_ff  <= loff_in;
         cleft_ff <= cleft_in;
         seq_ff   <= seq_in;
         hold_ff  <= cfg.wr;
      end
      bpp_ff    <= bpp_in;
      height_ff <= height_in;
      lbytes_ff <= lbytes_in;
      room_ff   <= room_in;
      bad_ff    <= bad_in;
      byte_ff   <= byte_in;
      chunk_ff  <= chunk_in;
      cont_ff   <= cont_in;
   end

endmodule

### hdl/rvlp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_queue
// Short request queue between front end and packet emitter.
// ----------------------------------------------------------------------------
module rvlp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rvlp_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                head_valid,
   output rvlp_pkg::entry_type head,
   output logic                room
);

   rvlp_pkg::entry_type           mem_ff [rvlp_pkg::QUEUE_DEPTH];
   logic [rvlp_pkg::QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [rvlp_pkg::QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [rvlp_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                          do_pop;

   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rptr_ff];
   assign room       = cnt_ff != rvlp_pkg::QCNT_W'(rvlp_pkg::QUEUE_DEPTH);
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in = push_valid ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (push_valid && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push_valid) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/rvlp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_back
// Packet emitter: sends the data byte of each queued request, after the
// 20 header bytes when it opens a packet, through a registered output stage.
// ----------------------------------------------------------------------------
module rvlp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rvlp_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic [2:0]          rsp_tuser,
   output logic                rsp_tlast
);

   rvlp_pkg::entry_type             cur_ff;
   logic                            cur_valid_ff;
   logic [rvlp_pkg::IDX_W-1:0]      idx_ff;
   logic                            out_valid_ff;
   logic [7:0]                      out_byte_ff;
   logic [2:0]                      out_user_ff;
   logic                            out_last_ff;
   logic                            out_ok, emit, last, cur_take;
   logic [7:0]                      byte_sel;

   assign out_ok   = !out_valid_ff || rsp_tready;
   assign emit     = cur_valid_ff && out_ok;
   assign last     = idx_ff == rvlp_pkg::IDX_DATA;
   assign cur_take = !cur_valid_ff || (emit && last);
   assign pop      = cur_take && head_valid;

   always_comb begin
      unique case (idx_ff) inside
         [rvlp_pkg::IDX_ZERO_LO:rvlp_pkg::IDX_ZERO_HI]: byte_sel = 8'h00;
         rvlp_pkg::IDX_SEQ_HI:  byte_sel = cur_ff.seq[15:8];
         rvlp_pkg::IDX_SEQ_LO:  byte_sel = cur_ff.seq[7:0];
         rvlp_pkg::IDX_LEN_HI:  byte_sel = {2'b00, cur_ff.chunk[13:8]};
         rvlp_pkg::IDX_LEN_LO:  byte_sel = cur_ff.chunk[7:0];
         rvlp_pkg::IDX_LINE_HI: byte_sel = {1'b0, cur_ff.line[14:8]};
         rvlp_pkg::IDX_LINE_LO: byte_sel = cur_ff.line[7:0];
         rvlp_pkg::IDX_OFFS_HI: byte_sel = cur_ff.offs[15:8];
         rvlp_pkg::IDX_OFFS_LO: byte_sel = cur_ff.offs[7:0];
         rvlp_pkg::IDX_DATA:    byte_sel = cur_ff.data;
         default:               byte_sel = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cur_take) begin
            cur_valid_ff <= head_valid;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cur_take) begin
         cur_ff <= head;
         idx_ff <= head.hdr ? rvlp_pkg::IDX_FIRST : rvlp_pkg::IDX_DATA;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (emit) begin
         out_byte_ff <= byte_sel;
         out_user_ff <= {cur_ff.frame_end && last, cur_ff.pkt_end && last,
                         idx_ff == rvlp_pkg::IDX_FIRST};
         out_last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### hdl/raw_video_line_packetizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_video_line_packetizer_top
// Cuts a raw video frame into line packets with 20-byte headers.
// ----------------------------------------------------------------------------
// Usage:
//  req_* takes the frame one byte per request in raster order. rsp_* gives
//  the packet stream one byte per transfer; tuser flags packet start, packet
//  end and frame end, tlast marks the last byte caused by one request.
//  csr_* writes frame width, height, bits per pixel and max payload; write
//  only while idle. The request side stalls in the cycle after a write.
// Flow: a byte in an open packet is queued when taken, then passes the
//  emitter's current-request and output registers to rsp_*. A byte that
//  opens a packet holds the front end through a setup state that starts
//  the bit-serial pixel offset divider and a wait state for the quotient;
//  the request's 21 bytes then leave at one per cycle while rsp_tready is
//  high. A two-entry queue lets the front end run ahead while the output
//  drains.
// Reset: synchronous; position, sequence number and queue clear and the
//  registers return to 1920 x 1080, 24 bpp, 1440 byte payload.
// Stall: a held rsp_tready keeps the output byte stable; the queue fills
//  and req_tready drops.
// ----------------------------------------------------------------------------
module raw_video_line_packetizer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic [2:0]                      rsp_tuser,   // [0] pkt_start [1] pkt_end [2] frame_end
   output logic                            rsp_tlast,   // run_last
   input  logic                            csr_wr_en,
   input  logic [rvlp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rvlp_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   logic [rvlp_pkg::FW_W-1:0]   width_ff;
   logic [rvlp_pkg::FH_W-1:0]   height_ff;
   logic [rvlp_pkg::BPP_W-1:0]  bpp_ff;
   logic [rvlp_pkg::MP_W-1:0]   maxpl_ff;

   rvlp_pkg::cfg_type     cfg;
   rvlp_pkg::entry_type   push_entry, head;
   rvlp_pkg::div_req_type div_req;
   rvlp_pkg::div_rsp_type div_rsp;
   logic                  push_valid, pop, head_valid, q_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rvlp_pkg::RST_WIDTH;
         height_ff <= rvlp_pkg::RST_HEIGHT;
         bpp_ff    <= rvlp_pkg::RST_BPP;
         maxpl_ff  <= rvlp_pkg::RST_MAXPL;
      end else if (csr_wr_en) begin
         unique case (rvlp_pkg::csr_index_type'(csr_addr))
            rvlp_pkg::CSR_FRAME_WIDTH:    width_ff  <= csr_wr_data[rvlp_pkg::FW_W-1:0];
            rvlp_pkg::CSR_FRAME_HEIGHT:   height_ff <= csr_wr_data[rvlp_pkg::FH_W-1:0];
            rvlp_pkg::CSR_BITS_PER_PIXEL: bpp_ff    <= csr_wr_data[rvlp_pkg::BPP_W-1:0];
            rvlp_pkg::CSR_MAX_PAYLOAD:    maxpl_ff  <= csr_wr_data[rvlp_pkg::MP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.wr          = csr_wr_en;
      cfg.width       = width_ff;
      cfg.height      = height_ff;
      cfg.bpp         = bpp_ff;
      cfg.max_payload = maxpl_ff;
   end

   rvlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_room     (q_room),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   rvlp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rvlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .room       (q_room)
   );

   rvlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hdl/rvlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvlp_checker
// Port-level checks of the packet stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvlp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [7:0]                      rsp_tdata,
   input logic [2:0]                      rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            csr_wr_en,
   input logic [rvlp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [rvlp_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   // a stalled output byte holds
   `RVLP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a header's first byte is never the data byte of a request
   `RVLP_ASSERT(a_start_not_last, clock, reset, rsp_tvalid && rsp_tuser[0] |-> !rsp_tlast)

   // packet end and frame end only on the data byte, frame end closes a packet
   `RVLP_ASSERT(a_end_on_data, clock, reset, rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> rsp_tlast && rsp_tuser[1])

   // nothing leaves right after reset
   `RVLP_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid)

endmodule

bind raw_video_line_packetizer_top rvlp_checker u_rvlp_checker (.*);

### tb/packet_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_stream_checker
// Follows register writes and accepted frame bytes, works out the packet
// bytes each request must produce and compares them in order with the
// response stream. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module packet_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   input  logic [2:0]                      rsp_tuser,   // [0] pkt_start [1] pkt_end [2] frame_end
   input  logic                            rsp_tlast,   // run_last
   input  logic                            csr_wr_en,
   input  logic [rvlp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rvlp_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                              mismatches,
   output int                              bytes_due
);
   import rvlp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       pkt_start;
      logic       pkt_end;
      logic       frame_end;
      logic       run_last;
   } pkt_byte_t;

   // register copies
   logic [FW_W-1:0]    fmt_width;
   logic [FH_W-1:0]    fmt_height;
   logic [BPP_W-1:0]   fmt_bpp;
   logic [MP_W-1:0]    fmt_payload;

   // position in the frame
   logic [LINE_W-1:0]   line_no;
   logic [LBYTES_W-1:0] line_pos;
   logic [CHUNK_W-1:0]  chunk_rem;
   logic [SEQ_W-1:0]    seq_num;

   pkt_byte_t due_bytes[$];

   function automatic void queue_byte(input logic [7:0] d, input logic s, input logic pe,
                                      input logic fe, input logic rl);
      pkt_byte_t b;
      b.data      = d;
      b.pkt_start = s;
      b.pkt_end   = pe;
      b.frame_end = fe;
      b.run_last  = rl;
      due_bytes.push_back(b);
   endfunction

   // header (when a packet opens) plus the data byte for one frame byte
   function automatic void packetize_byte(input logic [7:0] pix);
      int unsigned bpp, height, line_len, room, remaining, chunk, offs;
      logic        at_pkt_end, at_frame_end;
      bpp          = (fmt_bpp > BPP_MAX) ? 64 : fmt_bpp;
      height       = (fmt_height > HEIGHT_MAX) ? 32768 : fmt_height;
      line_len     = (fmt_width * bpp) / 8;
      at_pkt_end   = 1'b0;
      at_frame_end = 1'b0;
      if (fmt_payload <= RTP_FIXED || line_len == 0 || height == 0 || bpp == 0)
         return;
      if (chunk_rem == '0) begin
         room = fmt_payload - RTP_FIXED;
         if (line_no >= height) line_no = '0;
         if (line_pos >= line_len) line_pos = '0;
         remaining = line_len - line_pos;
         chunk     = (remaining < room) ? remaining : room;
         offs      = ((line_pos * 8) / bpp) & 32'h7FFF;
         if (remaining > chunk) offs = offs | 32'h8000;   // more of the line follows
         for (int i = 0; i < 12; i++) queue_byte(8'h00, i == 0, 1'b0, 1'b0, 1'b0);
         queue_byte(seq_num[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(seq_num[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(chunk[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(chunk[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte({1'b0, line_no[14:8]}, 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(line_no[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(offs[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
         queue_byte(offs[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
         chunk_rem = chunk[CHUNK_W-1:0];
      end
      chunk_rem = chunk_rem - 1'b1;
      line_pos  = line_pos + 1'b1;
      if (chunk_rem == '0) begin
         at_pkt_end = 1'b1;
         seq_num    = seq_num + 1'b1;
         // an open chunk may overrun a line that shrank meanwhile
         if (line_pos >= line_len) begin
            line_pos = '0;
            if (line_no + 1 >= height) begin
               at_frame_end = 1'b1;
               line_no      = '0;
               seq_num      = '0;
            end else begin
               line_no = line_no + 1'b1;
            end
         end
      end
      queue_byte(pix, 1'b0, at_pkt_end, at_frame_end, 1'b1);
   endfunction

   always @(posedge clock) begin
      pkt_byte_t seen, want;
      if (reset) begin
         fmt_width   = RST_WIDTH;
         fmt_height  = RST_HEIGHT;
         fmt_bpp     = RST_BPP;
         fmt_payload = RST_MAXPL;
         line_no     = '0;
         line_pos    = '0;
         chunk_rem   = '0;
         seq_num     = '0;
         mismatches  = 0;
         due_bytes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.data      = rsp_tdata;
            seen.pkt_start = rsp_tuser[0];
            seen.pkt_end   = rsp_tuser[1];
            seen.frame_end = rsp_tuser[2];
            seen.run_last  = rsp_tlast;
            if (due_bytes.size() == 0) begin
               $display("%0t: unexpected packet byte data=%02h start=%b end=%b frame_end=%b last=%b",
                        $time, seen.data, seen.pkt_start, seen.pkt_end, seen.frame_end,
                        seen.run_last);
               mismatches++;
            end else begin
               want = due_bytes.pop_front();
               if (seen !== want) begin
                  $display("%0t: packet byte mismatch, expected data=%02h start=%b end=%b frame_end=%b last=%b, actual data=%02h start=%b end=%b frame_end=%b last=%b",
                           $time, want.data, want.pkt_start, want.pkt_end, want.frame_end,
                           want.run_last, seen.data, seen.pkt_start, seen.pkt_end,
                           seen.frame_end, seen.run_last);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index_type'(csr_addr))
               CSR_FRAME_WIDTH:    fmt_width   = csr_wr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT:   fmt_height  = csr_wr_data[FH_W-1:0];
               CSR_BITS_PER_PIXEL: fmt_bpp     = csr_wr_data[BPP_W-1:0];
               CSR_MAX_PAYLOAD:    fmt_payload = csr_wr_data[MP_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) packetize_byte(req_tdata);
      end
      bytes_due = due_bytes.size();
   end

endmodule

### tb/raw_video_line_packetizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_video_line_packetizer_top_tb
// Drives frame bytes and register writes into the packetizer under several
// frame formats, with random gaps and back-pressure; the stream checker
// predicts every packet byte and the verdict comes from its mismatch count.
// ----------------------------------------------------------------------------
module raw_video_line_packetizer_top_tb;
   import rvlp_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_BYTES  = 400;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int mismatches;
   int bytes_due;
   int gap_pct   = 0;
   int stall_pct = 0;
   int cycles    = 0;

   raw_video_line_packetizer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   packet_stream_checker stream_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .bytes_due   (bytes_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one request; returns at the falling edge after it was taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold requests until every packet byte is out and the front end is quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= value[CSR_DATA_W-1:0];
      @(negedge clock);
   endtask

   task automatic write_format(input int w, input int h, input int bpp, input int mp);
      drain();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_BITS_PER_PIXEL, bpp);
      write_reg(CSR_MAX_PAYLOAD, mp);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int live, burst, kind, phase, w, h, bpp, mp;
      live  = 0;
      phase = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset     <= 1'b0;
      gap_pct   = 35;
      stall_pct = 35;

      // two 3-byte lines in chunks of 2 and 1: continuation, next line, frame end
      write_format(3, 2, 8, 10);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h01);
      send_byte(8'h80);

      // dropped: payload too small, zero payload and bpp, empty line, no lines
      write_format(3, 2, 8, 8);
      send_byte(8'h5A);
      write_format(1, 2, 0, 0);
      send_byte(8'hA5);
      write_format(1, 2, 7, 10);
      send_byte(8'h3C);
      write_format(3, 0, 8, 10);
      send_byte(8'hC3);

      // widest line, bpp and height above their clamps, one byte per packet
      write_format(32767, 16'hFFFF, 127, 9);
      send_byte(8'h0F);
      send_byte(8'hF0);
      send_byte(8'h96);

      // line cut below the current offset: restarts at offset zero
      write_format(2, 3, 8, 16383);
      send_byte(8'h69);
      send_byte(8'h7E);

      // chunk of 5 left open while the line shrinks to 2 bytes
      write_format(5, 3, 8, 16383);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      write_format(2, 3, 8, 16383);
      send_byte(8'h44);
      send_byte(8'h88);

      // height cut below the current line
      write_format(2, 2, 8, 16383);
      send_byte(8'hE7);

      while (live < RANDOM_BYTES) begin
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 65; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 65; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase
         kind = $urandom_range(9);
         if (kind == 0) begin
            w   = 32767;
            h   = $urandom_range(1) ? 32768 : 65535;
            bpp = $urandom_range(64, 127);
            mp  = $urandom_range(9, 12);
         end else if (kind == 1) begin
            // payload too small: the whole burst is dropped
            w   = $urandom_range(1, 24);
            h   = $urandom_range(1, 4);
            bpp = $urandom_range(1, 64);
            mp  = $urandom_range(0, 8);
         end else begin
            w   = $urandom_range(1, 24);
            h   = $urandom_range(1, 4);
            bpp = ($urandom_range(3) == 0) ? $urandom_range(1, 127) : 8 * $urandom_range(1, 4);
            mp  = ($urandom_range(4) == 0) ? $urandom_range(41, 16383) : $urandom_range(9, 40);
         end
         write_format(w, h, bpp, mp);
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            if ($urandom_range(99) < 2) drain();
            send_byte($urandom_range(255));
            if (mp > 8 && w * bpp >= 8) live++;
         end
         phase++;
      end

      drain();
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
